// ----- hw/rtl/lbsa_pkg.sv -----
// Package for the log binned spectrum average block.
// Shared types, constants and a helper function; no dependencies.
package lbsa_pkg;

  localparam int MAX_BINS_DEF  = 64;
  localparam int SUM_WIDTH_DEF = 56;
  localparam int CNT_W         = 24;
  localparam int VAL_W         = 32;
  localparam int LOG_ITERS     = 16;

  // configuration register indexes
  localparam logic [2:0] REG_K_LOW      = 3'd0;
  localparam logic [2:0] REG_K_HIGH     = 3'd1;
  localparam logic [2:0] REG_BIN_COUNT  = 3'd2;
  localparam logic [2:0] REG_LOG_K_LOW  = 3'd3;
  localparam logic [2:0] REG_INV_STEP   = 3'd4;
  localparam logic [2:0] REG_FIRST_CTR  = 3'd5;
  localparam logic [2:0] REG_STEP_RATIO = 3'd6;

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  typedef struct packed {
    logic [31:0] k_low;
    logic [31:0] k_high;
    logic [6:0]  bin_count;
    logic [31:0] log_k_low;
    logic [31:0] inv_step;
    logic [31:0] first_centre;
    logic [31:0] step_ratio;
  } cfg_t;

  typedef struct packed {
    logic        command;
    logic [31:0] k_value;
    logic [31:0] power_value;
  } item_t;

  // position of the top set bit, 0 for zero
  function automatic logic [4:0] top_bit(input logic [31:0] v);
    logic [4:0] r;
    r = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) r = 5'(i);
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/lbsa_ifs.sv -----
// Channel interfaces: sample input, bin result output, config write.
// No dependencies.
interface lbsa_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] k_value;
  logic [31:0] power_value;
  modport source(output valid, command, k_value, power_value, input ready);
  modport sink(input valid, command, k_value, power_value, output ready);
endinterface

interface lbsa_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  bin_index;
  logic [31:0] bin_centre;
  logic [31:0] mean_power;
  logic [23:0] sample_count;
  logic        last_bin;
  modport source(output valid, bin_index, bin_centre, mean_power, sample_count, last_bin,
                 input ready);
  modport sink(input valid, bin_index, bin_centre, mean_power, sample_count, last_bin,
               output ready);
endinterface

interface lbsa_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- hw/rtl/lbsa_front.sv -----
// Front end: two-entry word queue between input channel and back end.
// Depends on lbsa_pkg.
module lbsa_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  lbsa_pkg::item_t in_item,
  output logic          q_valid,
  input  logic          q_ready,
  output lbsa_pkg::item_t q_item
);
  import lbsa_pkg::*;

  item_t      ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = ent_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= in_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule

// ----- hw/rtl/lbsa_back.sv -----
// Back end: log2, bin compute, accumulate into bin memory, finish sweep with divider.
// Depends on lbsa_pkg.
module lbsa_back #(
  parameter int MAX_BINS  = lbsa_pkg::MAX_BINS_DEF,
  parameter int SUM_WIDTH = lbsa_pkg::SUM_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  lbsa_pkg::cfg_t  cfg,
  input  logic            q_valid,
  output logic            q_ready,
  input  lbsa_pkg::item_t q_item,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [5:0]      out_bin_index,
  output logic [31:0]     out_bin_centre,
  output logic [31:0]     out_mean_power,
  output logic [23:0]     out_sample_count,
  output logic            out_last_bin
);
  import lbsa_pkg::*;

  localparam int BIN_W  = $clog2(MAX_BINS);
  localparam int MEM_W  = SUM_WIDTH + CNT_W;
  localparam int STEP_W = $clog2(SUM_WIDTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_LOG, S_DIFF, S_MULH, S_MULL, S_BIN, S_RD, S_ACC,
    S_FRD, S_FLD, S_DIV, S_FOUT, S_FC
  } state_t;

  state_t               state_r;
  logic [4:0]           top_r;
  logic [31:0]          m_r;
  logic [15:0]          frac_r;
  logic [3:0]           it_r;
  logic [16:0]          hi_r;
  logic [15:0]          lo_r;
  logic [48:0]          prodh_r;
  logic [31:0]          prodl_r;
  logic [BIN_W-1:0]     bin_r;
  logic [31:0]          p_r;
  logic [MAX_BINS-1:0]  vld_r;
  logic [BIN_W-1:0]     j_r;
  logic [31:0]          c_r;
  logic [63:0]          cprod_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [CNT_W:0]       rem_r;
  logic [SUM_WIDTH-1:0] dq_r;
  logic [STEP_W-1:0]    step_r;
  logic [MEM_W-1:0]     mem [MAX_BINS];
  logic [MEM_W-1:0]     rd_r;
  logic                 out_v_r;
  logic [5:0]           o_idx_r;
  logic [31:0]          o_ctr_r, o_mean_r;
  logic [23:0]          o_cnt_r;
  logic                 o_last_r;

  // bins in use minus one
  logic [BIN_W-1:0] nm1;
  always_comb begin
    if (cfg.bin_count == 7'd0)                nm1 = '0;
    else if (cfg.bin_count > 7'(MAX_BINS))    nm1 = BIN_W'(MAX_BINS - 1);
    else                                      nm1 = BIN_W'(cfg.bin_count - 7'd1);
  end

  // log iteration: square mantissa, pull one fraction bit
  logic [63:0] sq;
  logic [32:0] sq_t;
  assign sq   = 64'(m_r) * 64'(m_r);
  assign sq_t = sq[63:31];

  // difference to log of k_low
  logic [5:0]         tm;
  logic signed [34:0] lk, d;
  assign tm = {1'b0, top_r} - 6'd16;
  assign lk = {{13{tm[5]}}, tm, frac_r};
  assign d  = lk - {{3{cfg.log_k_low[31]}}, cfg.log_k_low};

  logic [49:0] bsum;
  logic [33:0] binw;
  assign bsum = 50'(prodh_r) + 50'(prodl_r);
  assign binw = bsum[49:16];

  // accumulate
  logic [SUM_WIDTH-1:0] old_s;
  logic [CNT_W-1:0]     old_c;
  logic [SUM_WIDTH:0]   add_s;
  logic [MEM_W-1:0]     wr_d;
  logic                 rd_en, wr_en;
  logic [BIN_W-1:0]     rd_a;
  logic                 rd_vld;
  assign rd_vld = (state_r == S_ACC) ? vld_r[bin_r] : vld_r[j_r];
  assign old_s  = rd_vld ? rd_r[MEM_W-1:CNT_W] : '0;
  assign old_c  = rd_vld ? rd_r[CNT_W-1:0] : '0;
  assign add_s  = {1'b0, old_s} + (SUM_WIDTH+1)'(p_r);
  always_comb begin
    wr_d[MEM_W-1:CNT_W] = add_s[SUM_WIDTH] ? '1 : add_s[SUM_WIDTH-1:0];
    wr_d[CNT_W-1:0]     = (&old_c) ? old_c : old_c + CNT_W'(1);
  end
  assign wr_en = (state_r == S_ACC);
  assign rd_en = (state_r == S_RD) || (state_r == S_FRD);
  assign rd_a  = (state_r == S_FRD) ? j_r : bin_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[bin_r] <= wr_d;
    if (rd_en) rd_r <= mem[rd_a];
  end

  // restoring divide step
  logic [CNT_W:0] dr;
  logic           ge;
  assign dr = {rem_r[CNT_W-1:0], dq_r[SUM_WIDTH-1]};
  assign ge = dr >= {1'b0, cnt_r};

  logic        range_bad;
  logic [4:0]  tb;
  assign tb = top_bit(q_item.k_value);
  assign range_bad = (q_item.k_value == 32'd0) || (q_item.k_value < cfg.k_low) ||
                     (q_item.k_value > cfg.k_high);

  assign q_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vld_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      // S_FOUT owns the output register on its own cycle
      if (out_v_r && out_ready && state_r != S_FOUT) out_v_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            if (q_item.command == CMD_FINISH) begin
              j_r     <= '0;
              c_r     <= cfg.first_centre;
              state_r <= S_FRD;
            end else if (!range_bad) begin
              top_r   <= tb;
              m_r     <= q_item.k_value << (5'd31 - tb);
              p_r     <= q_item.power_value;
              frac_r  <= '0;
              it_r    <= '0;
              state_r <= S_LOG;
            end
          end
        end
        S_LOG: begin
          if (sq_t[32]) begin
            m_r    <= sq_t[32:1];
            frac_r <= {frac_r[14:0], 1'b1};
          end else begin
            m_r    <= sq_t[31:0];
            frac_r <= {frac_r[14:0], 1'b0};
          end
          it_r <= it_r + 4'd1;
          if (it_r == 4'(LOG_ITERS - 1)) state_r <= S_DIFF;
        end
        S_DIFF: begin
          hi_r <= d[32:16];
          lo_r <= d[15:0];
          if (d[34] || d == '0) begin
            bin_r   <= '0;
            state_r <= S_RD;
          end else begin
            state_r <= S_MULH;
          end
        end
        S_MULH: begin
          prodh_r <= 49'(hi_r) * 49'(cfg.inv_step);
          state_r <= S_MULL;
        end
        S_MULL: begin
          prodl_r <= 32'((48'(lo_r) * 48'(cfg.inv_step)) >> 16);
          state_r <= S_BIN;
        end
        S_BIN: begin
          bin_r   <= (binw > 34'(nm1)) ? nm1 : binw[BIN_W-1:0];
          state_r <= S_RD;
        end
        S_RD: state_r <= S_ACC;
        S_ACC: begin
          vld_r[bin_r] <= 1'b1;
          state_r      <= S_IDLE;
        end
        S_FRD: state_r <= S_FLD;
        S_FLD: begin
          cnt_r  <= old_c;
          rem_r  <= '0;
          step_r <= '0;
          if (old_c == '0) begin
            dq_r    <= '0;
            state_r <= S_FOUT;
          end else begin
            dq_r    <= old_s;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r  <= ge ? dr - {1'b0, cnt_r} : dr;
          dq_r   <= {dq_r[SUM_WIDTH-2:0], ge};
          step_r <= step_r + STEP_W'(1);
          if (step_r == STEP_W'(SUM_WIDTH - 1)) state_r <= S_FOUT;
        end
        S_FOUT: begin
          if (!out_v_r || out_ready) begin
            out_v_r  <= 1'b1;
            o_idx_r  <= 6'(j_r);
            o_ctr_r  <= c_r;
            o_mean_r <= (|dq_r[SUM_WIDTH-1:32]) ? '1 : dq_r[31:0];
            o_cnt_r  <= cnt_r;
            o_last_r <= (j_r == nm1);
            cprod_r  <= 64'(c_r) * 64'(cfg.step_ratio);
            state_r  <= S_FC;
          end
        end
        S_FC: begin
          c_r <= (|cprod_r[63:48]) ? '1 : cprod_r[47:16];
          if (j_r == nm1) begin
            vld_r   <= '0;
            state_r <= S_IDLE;
          end else begin
            j_r     <= j_r + BIN_W'(1);
            state_r <= S_FRD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_v_r;
  assign out_bin_index    = o_idx_r;
  assign out_bin_centre   = o_ctr_r;
  assign out_mean_power   = o_mean_r;
  assign out_sample_count = o_cnt_r;
  assign out_last_bin     = o_last_r;
endmodule

// ----- hw/rtl/log_binned_spectrum_average_top.sv -----
// Top level of the log binned spectrum average block.
// Depends on lbsa_pkg, lbsa_ifs, lbsa_front, lbsa_back.
//
// Usage:
//  - in_if carries words {command, k_value, power_value}. An add word puts a
//    Q16.16 (wavenumber, power) sample into its logarithmic bin; a finish
//    word emits one out_if word per bin in use, in bin order, then empties
//    all bins. last_bin marks the final word of a finish run.
//  - cfg_if writes the seven setup registers by index; always ready. Write
//    only while the block is idle.
//  - Add: per sample the back end steps through accept, 16 log2 squaring
//    steps on one 32x32 multiplier, difference, two products, bin clamp,
//    bin memory read and write; when the log difference is not positive,
//    the products and the clamp are skipped and the sample goes to bin 0.
//    Out-of-range samples are dropped when accepted.
//  - Finish: each bin is read, divided by the bit-serial mean divider
//    (one quotient bit per cycle over SUM_WIDTH bits), then put in the
//    output register; an empty bin skips the divider. A stalled receiver
//    holds the bin waiting on the output register.
//  - A two-word queue decouples in_if from the back end, and an output
//    register decouples out_if: a stalled receiver only stops the finish
//    sweep, the queue keeps taking words until full.
//  - Reset: registers return to defaults, all bins read as empty (per-bin
//    valid bits), queue and output register empty. No clearing pass.
module log_binned_spectrum_average_top #(
  parameter int MAX_BINS  = lbsa_pkg::MAX_BINS_DEF,
  parameter int SUM_WIDTH = lbsa_pkg::SUM_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  lbsa_in_if.sink   in_if,
  lbsa_out_if.source out_if,
  lbsa_cfg_if.sink  cfg_if
);
  import lbsa_pkg::*;

  cfg_t  cfg_r;
  item_t in_item, q_item;
  logic  q_valid, q_ready;

  // setup registers
  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.k_low        <= 32'd65536;
      cfg_r.k_high       <= 32'd4194304;
      cfg_r.bin_count    <= 7'd64;
      cfg_r.log_k_low    <= 32'd0;
      cfg_r.inv_step     <= 32'd699051;
      cfg_r.first_centre <= 32'd65536;
      cfg_r.step_ratio   <= 32'd65536;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_K_LOW:      cfg_r.k_low        <= cfg_if.data;
        REG_K_HIGH:     cfg_r.k_high       <= cfg_if.data;
        REG_BIN_COUNT:  cfg_r.bin_count    <= cfg_if.data[6:0];
        REG_LOG_K_LOW:  cfg_r.log_k_low    <= cfg_if.data;
        REG_INV_STEP:   cfg_r.inv_step     <= cfg_if.data;
        REG_FIRST_CTR:  cfg_r.first_centre <= cfg_if.data;
        REG_STEP_RATIO: cfg_r.step_ratio   <= cfg_if.data;
        default: ;
      endcase
    end
  end

  assign in_item.command     = in_if.command;
  assign in_item.k_value     = in_if.k_value;
  assign in_item.power_value = in_if.power_value;

  lbsa_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  lbsa_back #(
    .MAX_BINS  (MAX_BINS),
    .SUM_WIDTH (SUM_WIDTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_valid          (q_valid),
    .q_ready          (q_ready),
    .q_item           (q_item),
    .out_valid        (out_if.valid),
    .out_ready        (out_if.ready),
    .out_bin_index    (out_if.bin_index),
    .out_bin_centre   (out_if.bin_centre),
    .out_mean_power   (out_if.mean_power),
    .out_sample_count (out_if.sample_count),
    .out_last_bin     (out_if.last_bin)
  );
endmodule

// ----- hw/rtl/lbsa_checker.sv -----
// Port-level checks for the log binned spectrum average top, with bind.
// Depends on log_binned_spectrum_average_top.
module lbsa_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [5:0] out_bin_index,
  input logic       out_last_bin,
  input logic       cfg_ready
);
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_bin_index))
    else $error("result dropped or changed while stalled");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("config port not ready");

  a_top_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bin_index == 6'd63 |-> out_last_bin)
    else $error("bin 63 not marked last");
endmodule

bind log_binned_spectrum_average_top lbsa_checker u_lbsa_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .out_bin_index (out_if.bin_index),
  .out_last_bin  (out_if.last_bin),
  .cfg_ready     (cfg_if.ready)
);
